[rtl/core/mbx_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and constants for the mailbox exchange sequencer.
// Used by mbx_step and the top level; no dependencies of its own.
package mbx_pkg;

    // Command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_QUEUE = 2'd1;
    localparam logic [1:0] CMD_RESET = 2'd2;

    // Transport poll codes
    localparam logic [1:0] TS_BUSY     = 2'd0;
    localparam logic [1:0] TS_COMPLETE = 2'd1;

    // Exchange phases
    localparam logic [2:0] PH_CTRL_QUEUE  = 3'd0;
    localparam logic [2:0] PH_CTRL_WAIT   = 3'd1;
    localparam logic [2:0] PH_READ_WAIT   = 3'd2;
    localparam logic [2:0] PH_WRITE_WAIT  = 3'd3;
    localparam logic [2:0] PH_STATUS_WAIT = 3'd4;

    // Event codes
    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_FAILED  = 3'd1;
    localparam logic [2:0] EV_READ    = 3'd2;
    localparam logic [2:0] EV_WRITTEN = 3'd3;
    localparam logic [2:0] EV_STATUS  = 3'd4;

    // Request kinds
    localparam logic [2:0] RQ_NONE    = 3'd0;
    localparam logic [2:0] RQ_CONTROL = 3'd1;
    localparam logic [2:0] RQ_STATUS  = 3'd2;
    localparam logic [2:0] RQ_PREAD   = 3'd3;
    localparam logic [2:0] RQ_PWRITE  = 3'd4;

    // Remote record offsets and sizes
    localparam logic [7:0]  OFS_PAYLOAD     = 8'h80;
    localparam logic [7:0]  OFS_LENGTH      = 8'h81;
    localparam logic [7:0]  OFS_CONTROL     = 8'h82;
    localparam logic [7:0]  OFS_STATUS      = 8'h90;
    localparam logic [15:0] RECORD_BYTES    = 16'd4;
    localparam logic [7:0]  RETRY_THRESHOLD = 8'd1;
    localparam logic [7:0]  RETRY_MAX       = 8'd255;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_RD_BUF_LIMIT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WRITE_LEN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STATUS_MASK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_CODE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_READY_MASK     = 3'd4;

    // Configuration reset values
    localparam logic [15:0] RST_RD_BUF_LIMIT  = 16'd256;
    localparam logic [15:0] RST_MAX_WRITE_LEN = 16'd256;
    localparam logic [7:0]  RST_STATUS_MASK   = 8'd3;
    localparam logic [7:0]  RST_RETRY_CODE    = 8'd1;
    localparam logic [7:0]  RST_READY_MASK    = 8'h80;

    typedef struct packed {
        logic [15:0] rd_buf_limit;
        logic [15:0] max_write_length;
        logic [7:0]  status_field_mask;
        logic [7:0]  retry_code;
        logic [7:0]  payload_ready_mask;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic [7:0]  retry_count;
        logic        write_pending;
        logic [7:0]  pending_tag;
        logic [15:0] pending_length;
        logic [15:0] rd_xfer_len;
    } xchg_state_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [1:0]  transport_state;
        logic        queue_accepted;
        logic [31:0] read_data;
        logic [7:0]  write_tag;
        logic [15:0] write_length_in;
    } item_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [15:0] payload_bytes;
        logic [31:0] status_word;
        logic [2:0]  request_kind;
        logic [7:0]  request_offset;
        logic [15:0] request_length;
        logic [7:0]  request_tag;
        logic        queue_ok;
    } result_t;

endpackage

[rtl/core/mbx_step.sv]
`timescale 1ns / 1ps
// Next-state and result logic for one sequencer item.
// Depends on mbx_pkg for codes, state, item and result types.
module mbx_step import mbx_pkg::*; (
    input  cfg_t        cfg,
    input  xchg_state_t state_cur,
    input  item_t       item,
    output xchg_state_t state_next,
    output result_t     result
);

    always_comb begin
        logic [7:0]  flags;
        logic [15:0] plen;
        logic [7:0]  retry_inc;
        logic        reject;

        flags     = item.read_data[31:24];
        plen      = item.read_data[15:0];
        retry_inc = (state_cur.retry_count == RETRY_MAX) ? RETRY_MAX
                                                         : state_cur.retry_count + 8'd1;
        reject    = (item.write_tag == 8'd0) || (item.write_length_in == 16'd0) ||
                    (item.write_length_in > cfg.max_write_length) ||
                    (state_cur.write_pending &&
                     ((item.write_tag != state_cur.pending_tag) ||
                      (state_cur.phase == PH_WRITE_WAIT)));

        state_next = state_cur;
        result     = '0;

        unique case (item.cmd)
            CMD_RESET: begin
                state_next = '0;
            end
            CMD_QUEUE: begin
                // Take the packet only under the pending and length rules
                if (!reject) begin
                    state_next.write_pending  = 1'b1;
                    state_next.pending_tag    = item.write_tag;
                    state_next.pending_length = item.write_length_in;
                    result.queue_ok           = 1'b1;
                end
            end
            CMD_TICK: begin
                if (state_cur.phase == PH_CTRL_QUEUE) begin
                    // Present the control record read
                    result.request_kind   = RQ_CONTROL;
                    result.request_offset = OFS_CONTROL;
                    result.request_length = RECORD_BYTES;
                    if (item.queue_accepted) begin
                        state_next.phase = PH_CTRL_WAIT;
                    end
                end else if (item.transport_state == TS_BUSY) begin
                    // Hold while the transport works
                end else if (item.transport_state != TS_COMPLETE) begin
                    state_next.phase = PH_CTRL_QUEUE;
                    result.event_res = EV_FAILED;
                end else if (state_cur.phase == PH_READ_WAIT) begin
                    state_next.phase     = PH_CTRL_QUEUE;
                    result.event_res     = EV_READ;
                    result.payload_bytes = state_cur.rd_xfer_len;
                end else if (state_cur.phase == PH_WRITE_WAIT) begin
                    state_next.phase          = PH_CTRL_QUEUE;
                    state_next.write_pending  = 1'b0;
                    state_next.pending_tag    = 8'd0;
                    state_next.pending_length = 16'd0;
                    result.event_res          = EV_WRITTEN;
                end else if (state_cur.phase == PH_STATUS_WAIT) begin
                    state_next.phase   = PH_CTRL_QUEUE;
                    result.event_res   = EV_STATUS;
                    result.status_word = item.read_data;
                end else if ((flags & cfg.status_field_mask) == cfg.retry_code) begin
                    // Retry: read status only from the second retry in a row
                    state_next.phase       = PH_CTRL_QUEUE;
                    state_next.retry_count = retry_inc;
                    if (retry_inc > RETRY_THRESHOLD) begin
                        result.request_kind   = RQ_STATUS;
                        result.request_offset = OFS_STATUS;
                        result.request_length = RECORD_BYTES;
                        if (item.queue_accepted) begin
                            state_next.retry_count = 8'd0;
                            state_next.phase       = PH_STATUS_WAIT;
                        end
                    end
                end else if ((flags & cfg.payload_ready_mask) != 8'd0) begin
                    state_next.retry_count = 8'd0;
                    state_next.phase       = PH_CTRL_QUEUE;
                    if (plen > cfg.rd_buf_limit) begin
                        result.event_res = EV_FAILED;
                    end else begin
                        result.request_kind   = RQ_PREAD;
                        result.request_offset = OFS_PAYLOAD;
                        result.request_length = plen;
                        if (item.queue_accepted) begin
                            state_next.rd_xfer_len = plen;
                            state_next.phase       = PH_READ_WAIT;
                        end else begin
                            result.event_res = EV_FAILED;
                        end
                    end
                end else if (state_cur.write_pending) begin
                    state_next.retry_count = 8'd0;
                    state_next.phase       = PH_CTRL_QUEUE;
                    result.request_kind    = RQ_PWRITE;
                    result.request_offset  = OFS_PAYLOAD;
                    result.request_length  = state_cur.pending_length;
                    result.request_tag     = state_cur.pending_tag;
                    if (item.queue_accepted) begin
                        state_next.phase = PH_WRITE_WAIT;
                    end else begin
                        result.event_res = EV_FAILED;
                    end
                end else begin
                    // Nothing to do: poll again
                    state_next.retry_count = 8'd0;
                    state_next.phase       = PH_CTRL_QUEUE;
                end
            end
            default: begin
                // Unused command: no effect
            end
        endcase
    end

endmodule

[rtl/core/mailbox_exchange_sequencer_unit.sv]
`timescale 1ns / 1ps
// Mailbox exchange sequencer: polls a remote mailbox through a shared transport.
// Depends on mbx_pkg and mbx_step.
//
// Input channel (s_*): one item per step, a command plus the transport poll
// results. Result channel (m_*): exactly one result item per input item,
// carrying the event and the request presented to the transport this step.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 read
// capacity, 1 max write length, 2 status mask, 3 retry code, 4 ready mask);
// write only while the block is idle. Unknown indexes are ignored.
//
// The item's result is in the output register the cycle after acceptance.
// Throughput is one item per cycle while the receiver takes results, set by
// the single output register; the exchange state updates at the same edge.
// When the receiver stalls, the output register holds its item and s_ready
// drops until it is taken; s_ready stays high while the register is empty or
// being drained in the same cycle.
// Synchronous reset (aresetn low) clears the exchange state, empties the
// output register and loads the configuration reset values.
module mailbox_exchange_sequencer_unit import mbx_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_wdata,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_cmd,
    input  logic [1:0]           s_transport_state,
    input  logic                 s_queue_accepted,
    input  logic [31:0]          s_read_data,
    input  logic [7:0]           s_write_tag,
    input  logic [15:0]          s_write_length_in,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_event_res,
    output logic [15:0]          m_payload_bytes,
    output logic [31:0]          m_status_word,
    output logic [2:0]           m_request_kind,
    output logic [7:0]           m_request_offset,
    output logic [15:0]          m_request_length,
    output logic [7:0]           m_request_tag,
    output logic                 m_queue_ok
);

    cfg_t        cfg_reg;
    xchg_state_t state_reg;
    xchg_state_t state_next;
    item_t       item;
    result_t     step_result;
    result_t     result_reg;
    logic        m_valid_reg;
    logic        s_fire;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    assign item = '{cmd:             s_cmd,
                    transport_state: s_transport_state,
                    queue_accepted:  s_queue_accepted,
                    read_data:       s_read_data,
                    write_tag:       s_write_tag,
                    write_length_in: s_write_length_in};

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rd_buf_limit       <= RST_RD_BUF_LIMIT;
            cfg_reg.max_write_length   <= RST_MAX_WRITE_LEN;
            cfg_reg.status_field_mask  <= RST_STATUS_MASK;
            cfg_reg.retry_code         <= RST_RETRY_CODE;
            cfg_reg.payload_ready_mask <= RST_READY_MASK;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_RD_BUF_LIMIT:  cfg_reg.rd_buf_limit       <= cfg_wdata;
                CFG_MAX_WRITE_LEN: cfg_reg.max_write_length   <= cfg_wdata;
                CFG_STATUS_MASK:   cfg_reg.status_field_mask  <= cfg_wdata[7:0];
                CFG_RETRY_CODE:    cfg_reg.retry_code         <= cfg_wdata[7:0];
                CFG_READY_MASK:    cfg_reg.payload_ready_mask <= cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    mbx_step u_step (
        .cfg        (cfg_reg),
        .state_cur  (state_reg),
        .item       (item),
        .state_next (state_next),
        .result     (step_result)
    );

    // Advance the exchange state on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (s_fire) begin
            state_reg <= state_next;
        end
    end

    // Output register: load on accept, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            result_reg <= step_result;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_event_res      = result_reg.event_res;
    assign m_payload_bytes  = result_reg.payload_bytes;
    assign m_status_word    = result_reg.status_word;
    assign m_request_kind   = result_reg.request_kind;
    assign m_request_offset = result_reg.request_offset;
    assign m_request_length = result_reg.request_length;
    assign m_request_tag    = result_reg.request_tag;
    assign m_queue_ok       = result_reg.queue_ok;

    // A reset command leaves a clean exchange
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_cmd == CMD_RESET) |=>
            (state_reg.phase == PH_CTRL_QUEUE && !state_reg.write_pending))
        else $error("exchange not cleared by reset command");

    // A written event retires the pending packet
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && step_result.event_res == EV_WRITTEN) |=> !state_reg.write_pending)
        else $error("pending packet kept after write completed");

    // Phase stays within the defined codes
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.phase <= PH_STATUS_WAIT)
        else $error("phase out of range");

    // No tag is held without a pending packet
    assert property (@(posedge aclk) disable iff (!aresetn)
        !state_reg.write_pending |-> (state_reg.pending_tag == 8'd0))
        else $error("stale pending tag");

    // A tag goes out only with a payload write request
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_request_tag != 8'd0) |-> (m_request_kind == RQ_PWRITE))
        else $error("tag on a request that is not a payload write");

endmodule

[bench/mbx_exchange_checker.sv]
`timescale 1ns / 1ps
// Checker for the mailbox exchange sequencer. It mirrors register writes, predicts one
// result item per accepted input item and compares the result items in order.
// Depends on mbx_pkg only.
module mbx_exchange_checker import mbx_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_wdata,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [1:0]           s_cmd,
    input  logic [1:0]           s_transport_state,
    input  logic                 s_queue_accepted,
    input  logic [31:0]          s_read_data,
    input  logic [7:0]           s_write_tag,
    input  logic [15:0]          s_write_length_in,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [2:0]           m_event_res,
    input  logic [15:0]          m_payload_bytes,
    input  logic [31:0]          m_status_word,
    input  logic [2:0]           m_request_kind,
    input  logic [7:0]           m_request_offset,
    input  logic [15:0]          m_request_length,
    input  logic [7:0]           m_request_tag,
    input  logic                 m_queue_ok,
    output int unsigned          mismatch_count,
    output int unsigned          results_owed
);

    cfg_t        regs;
    xchg_state_t xs;
    result_t     owed_results[$];
    int unsigned mismatches = 0;

    assign mismatch_count = mismatches;

    // Fill in the request that the block presents to the transport
    function automatic void present_request(inout result_t r, input logic [2:0] kind,
                                            input logic [7:0] ofs, input logic [15:0] len,
                                            input logic [7:0] tag);
        r.request_kind   = kind;
        r.request_offset = ofs;
        r.request_length = len;
        r.request_tag    = tag;
    endfunction

    // Advance the exchange by one item and return the result item it produces
    function automatic result_t advance_exchange(input item_t it);
        result_t     r;
        logic [7:0]  flags;
        logic [15:0] plen;
        logic        refuse;
        r     = '0;
        flags = it.read_data[31:24];
        plen  = it.read_data[15:0];
        if (it.cmd == CMD_RESET) begin
            xs = '0;
        end else if (it.cmd == CMD_QUEUE) begin
            refuse = it.write_tag == 8'h00 || it.write_length_in == 16'h0000 ||
                     it.write_length_in > regs.max_write_length ||
                     (xs.write_pending &&
                      (it.write_tag != xs.pending_tag || xs.phase == PH_WRITE_WAIT));
            if (!refuse) begin
                xs.write_pending  = 1'b1;
                xs.pending_tag    = it.write_tag;
                xs.pending_length = it.write_length_in;
                r.queue_ok        = 1'b1;
            end
        end else if (it.cmd != CMD_TICK) begin
            // spare command code: no effect at all
        end else if (xs.phase == PH_CTRL_QUEUE) begin
            // transport state does not matter here, only whether the read is taken
            present_request(r, RQ_CONTROL, OFS_CONTROL, RECORD_BYTES, 8'h00);
            if (it.queue_accepted)
                xs.phase = PH_CTRL_WAIT;
        end else if (it.transport_state == TS_BUSY) begin
            // hold the current wait phase
        end else if (it.transport_state != TS_COMPLETE) begin
            // failed, and the undefined code with it
            xs.phase    = PH_CTRL_QUEUE;
            r.event_res = EV_FAILED;
        end else if (xs.phase == PH_READ_WAIT) begin
            xs.phase        = PH_CTRL_QUEUE;
            r.event_res     = EV_READ;
            r.payload_bytes = xs.rd_xfer_len;
        end else if (xs.phase == PH_WRITE_WAIT) begin
            xs.phase          = PH_CTRL_QUEUE;
            xs.write_pending  = 1'b0;
            xs.pending_tag    = '0;
            xs.pending_length = '0;
            r.event_res       = EV_WRITTEN;
        end else if (xs.phase == PH_STATUS_WAIT) begin
            xs.phase      = PH_CTRL_QUEUE;
            r.event_res   = EV_STATUS;
            r.status_word = it.read_data;
        end else if ((flags & regs.status_field_mask) == regs.retry_code) begin
            // retry: count it, and read the status record from the second one on
            if (xs.retry_count != RETRY_MAX)
                xs.retry_count = xs.retry_count + 8'd1;
            xs.phase = PH_CTRL_QUEUE;
            if (xs.retry_count > RETRY_THRESHOLD) begin
                present_request(r, RQ_STATUS, OFS_STATUS, RECORD_BYTES, 8'h00);
                if (it.queue_accepted) begin
                    xs.retry_count = '0;
                    xs.phase       = PH_STATUS_WAIT;
                end
            end
        end else begin
            xs.retry_count = '0;
            xs.phase       = PH_CTRL_QUEUE;
            if ((flags & regs.payload_ready_mask) != 8'h00) begin
                // payload waiting: read it unless it overflows the buffer
                if (plen > regs.rd_buf_limit) begin
                    r.event_res = EV_FAILED;
                end else begin
                    present_request(r, RQ_PREAD, OFS_PAYLOAD, plen, 8'h00);
                    if (it.queue_accepted) begin
                        xs.rd_xfer_len = plen;
                        xs.phase       = PH_READ_WAIT;
                    end else begin
                        r.event_res = EV_FAILED;
                    end
                end
            end else if (xs.write_pending) begin
                present_request(r, RQ_PWRITE, OFS_PAYLOAD, xs.pending_length,
                                xs.pending_tag);
                if (it.queue_accepted)
                    xs.phase = PH_WRITE_WAIT;
                else
                    r.event_res = EV_FAILED;
            end
        end
        return r;
    endfunction

    // Compare one field of a result item and report a difference
    function automatic void check_field(input string label, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, label, want, got);
            mismatches++;
        end
    endfunction

    // Track registers and state, retire result items, then queue new predictions
    always @(posedge aclk) begin : monitor
        result_t want;
        result_t got;
        item_t   it;
        if (!aresetn) begin
            regs = '{rd_buf_limit: RST_RD_BUF_LIMIT, max_write_length: RST_MAX_WRITE_LEN,
                     status_field_mask: RST_STATUS_MASK, retry_code: RST_RETRY_CODE,
                     payload_ready_mask: RST_READY_MASK};
            xs = '0;
            owed_results.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_RD_BUF_LIMIT:  regs.rd_buf_limit       = cfg_wdata;
                    CFG_MAX_WRITE_LEN: regs.max_write_length   = cfg_wdata;
                    CFG_STATUS_MASK:   regs.status_field_mask  = cfg_wdata[7:0];
                    CFG_RETRY_CODE:    regs.retry_code         = cfg_wdata[7:0];
                    CFG_READY_MASK:    regs.payload_ready_mask = cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                got = {m_event_res, m_payload_bytes, m_status_word, m_request_kind,
                       m_request_offset, m_request_length, m_request_tag, m_queue_ok};
                if (owed_results.size() == 0) begin
                    $display("%0t: unexpected result item, expected none, got 0x%0h",
                             $time, got);
                    mismatches++;
                end else begin
                    want = owed_results.pop_front();
                    check_field("event_res", 32'(want.event_res), 32'(got.event_res));
                    check_field("payload_bytes", 32'(want.payload_bytes),
                                32'(got.payload_bytes));
                    check_field("status_word", want.status_word, got.status_word);
                    check_field("request_kind", 32'(want.request_kind),
                                32'(got.request_kind));
                    check_field("request_offset", 32'(want.request_offset),
                                32'(got.request_offset));
                    check_field("request_length", 32'(want.request_length),
                                32'(got.request_length));
                    check_field("request_tag", 32'(want.request_tag), 32'(got.request_tag));
                    check_field("queue_ok", 32'(want.queue_ok), 32'(got.queue_ok));
                end
            end
            if (s_valid && s_ready) begin
                it = {s_cmd, s_transport_state, s_queue_accepted, s_read_data, s_write_tag,
                      s_write_length_in};
                owed_results.push_back(advance_exchange(it));
            end
        end
        results_owed <= owed_results.size();
    end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// Top of the mailbox exchange sequencer bench: clock, reset, register settings, stimulus
// and the verdict. Depends on mbx_pkg, mailbox_exchange_sequencer_unit and the checker.
module testbench;
    import mbx_pkg::*;

    localparam logic [1:0] TS_FAILED    = 2'd2;
    localparam logic [1:0] TS_UNDEFINED = 2'd3;
    localparam logic [1:0] CMD_SPARE    = 2'd3;

    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int unsigned ITEMS_PER_PHASE = 40;
    localparam int unsigned RETRY_ROUNDS    = 260;

    logic                 aclk              = 1'b0;
    logic                 aresetn           = 1'b0;
    logic                 cfg_we            = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index         = '0;
    logic [15:0]          cfg_wdata         = '0;
    logic                 s_valid           = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_cmd             = '0;
    logic [1:0]           s_transport_state = '0;
    logic                 s_queue_accepted  = 1'b0;
    logic [31:0]          s_read_data       = '0;
    logic [7:0]           s_write_tag       = '0;
    logic [15:0]          s_write_length_in = '0;
    logic                 m_valid;
    logic                 m_ready           = 1'b0;
    logic [2:0]           m_event_res;
    logic [15:0]          m_payload_bytes;
    logic [31:0]          m_status_word;
    logic [2:0]           m_request_kind;
    logic [7:0]           m_request_offset;
    logic [15:0]          m_request_length;
    logic [7:0]           m_request_tag;
    logic                 m_queue_ok;
    int unsigned          mismatch_count;
    int unsigned          results_owed;
    int unsigned          cycle_count       = 0;
    bit                   tx_gaps           = 1'b1;
    cfg_t                 cfg_now = '{RST_RD_BUF_LIMIT, RST_MAX_WRITE_LEN, RST_STATUS_MASK,
                                      RST_RETRY_CODE, RST_READY_MASK};

    mailbox_exchange_sequencer_unit dut (.*);

    mbx_exchange_checker checker_inst (.*);

    always #6 aclk = ~aclk;

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    // Any item with every field random, then the command forced
    function automatic item_t command_item(input logic [1:0] cmd);
        item_t it;
        it.cmd             = cmd;
        it.transport_state = 2'($urandom);
        it.queue_accepted  = 1'($urandom);
        it.read_data       = $urandom;
        it.write_tag       = 8'($urandom);
        it.write_length_in = 16'($urandom);
        return it;
    endfunction

    function automatic item_t tick_item(input logic [1:0] ts, input logic acc,
                                        input logic [31:0] data);
        item_t it;
        it                 = command_item(CMD_TICK);
        it.transport_state = ts;
        it.queue_accepted  = acc;
        it.read_data       = data;
        return it;
    endfunction

    function automatic item_t queue_item(input logic [7:0] tag, input logic [15:0] len);
        item_t it;
        it                 = command_item(CMD_QUEUE);
        it.write_tag       = tag;
        it.write_length_in = len;
        return it;
    endfunction

    // Mostly ticks with records shaped by the current settings, plus packets and noise
    function automatic item_t random_item();
        item_t       it;
        int unsigned roll;
        logic [7:0]  flags;
        logic [15:0] plen;
        it   = command_item(CMD_TICK);
        roll = $urandom_range(0, 99);
        if (roll >= 97)
            it.cmd = CMD_SPARE;
        else if (roll >= 94)
            it.cmd = CMD_RESET;
        else if (roll >= 84)
            it.cmd = CMD_QUEUE;
        roll = $urandom_range(0, 19);
        it.transport_state = roll < 11 ? TS_COMPLETE : roll < 16 ? TS_BUSY :
                             roll < 19 ? TS_FAILED : TS_UNDEFINED;
        it.queue_accepted = ($urandom_range(0, 9) != 0);
        // flags: retry, payload ready, quiet or raw
        flags = 8'($urandom);
        roll  = $urandom_range(0, 9);
        if (roll < 3)
            flags = (flags & ~cfg_now.status_field_mask) | cfg_now.retry_code;
        else if (roll < 6)
            flags = flags | cfg_now.payload_ready_mask;
        else if (roll < 8)
            flags = flags & ~cfg_now.payload_ready_mask;
        // payload length: inside capacity, at it, just past it, or raw
        roll = $urandom_range(0, 9);
        if (roll < 7)
            plen = 16'($urandom_range(0, cfg_now.rd_buf_limit));
        else if (roll == 7)
            plen = cfg_now.rd_buf_limit;
        else if (roll == 8)
            plen = cfg_now.rd_buf_limit + 16'd1;
        else
            plen = 16'($urandom);
        it.read_data = {flags, it.read_data[23:16], plen};
        // a few recurring tags so that same-tag replacements happen
        if ($urandom_range(0, 9) < 7)
            it.write_tag = 8'($urandom_range(1, 3));
        roll = $urandom_range(0, 9);
        if (roll < 6)
            it.write_length_in = 16'($urandom_range(1, cfg_now.max_write_length));
        else if (roll == 6)
            it.write_length_in = cfg_now.max_write_length;
        else if (roll == 7)
            it.write_length_in = cfg_now.max_write_length + 16'd1;
        else if (roll == 8)
            it.write_length_in = '0;
        return it;
    endfunction

    // Present one item after a random gap and hold it until it is taken
    task automatic send_item(input item_t it);
        int unsigned gap;
        gap = tx_gaps ? $urandom_range(0, 6) : 0;
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid           <= 1'b1;
        s_cmd             <= it.cmd;
        s_transport_state <= it.transport_state;
        s_queue_accepted  <= it.queue_accepted;
        s_read_data       <= it.read_data;
        s_write_tag       <= it.write_tag;
        s_write_length_in <= it.write_length_in;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Drop valid and hold off until every predicted result item is back
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (results_owed != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // Write all five registers, one per cycle
    task automatic load_settings(input cfg_t c);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_RD_BUF_LIMIT;
        cfg_wdata <= c.rd_buf_limit;
        @(negedge aclk);
        cfg_index <= CFG_MAX_WRITE_LEN;
        cfg_wdata <= c.max_write_length;
        @(negedge aclk);
        cfg_index <= CFG_STATUS_MASK;
        cfg_wdata <= {8'h00, c.status_field_mask};
        @(negedge aclk);
        cfg_index <= CFG_RETRY_CODE;
        cfg_wdata <= {8'h00, c.retry_code};
        @(negedge aclk);
        cfg_index <= CFG_READY_MASK;
        cfg_wdata <= {8'h00, c.payload_ready_mask};
        @(negedge aclk);
        cfg_we <= 1'b0;
        cfg_now = c;
    endtask

    // Take result items after a random stall, with stretches of no stall
    initial begin : result_sink
        int unsigned stall;
        int unsigned taken;
        bit          rx_gaps;
        taken   = 0;
        rx_gaps = 1'b1;
        forever begin
            if (taken % 20 == 0)
                rx_gaps = ($urandom_range(0, 3) != 0);
            stall = rx_gaps ? $urandom_range(0, 6) : 0;
            @(negedge aclk);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            taken++;
        end
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        cfg_t c;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed walk through the exchange with reset settings
        send_item(tick_item(TS_FAILED, 1'b0, $urandom));        // control read refused
        send_item(tick_item(TS_UNDEFINED, 1'b1, $urandom));     // control read taken
        send_item(tick_item(TS_BUSY, 1'b1, $urandom));
        send_item(tick_item(TS_COMPLETE, 1'b1, 32'h0100_0010)); // first retry
        send_item(tick_item(TS_COMPLETE, 1'b1, $urandom));
        send_item(tick_item(TS_COMPLETE, 1'b0, 32'h0100_0010)); // status read refused
        send_item(tick_item(TS_BUSY, 1'b1, $urandom));
        send_item(tick_item(TS_COMPLETE, 1'b1, 32'h0100_0010)); // status read taken
        send_item(tick_item(TS_COMPLETE, 1'b1, 32'hFFFF_FFFF));
        send_item(tick_item(TS_COMPLETE, 1'b1, $urandom));
        send_item(tick_item(TS_COMPLETE, 1'b1, 32'h8000_FFFF)); // payload too long
        send_item(tick_item(TS_COMPLETE, 1'b1, $urandom));
        send_item(tick_item(TS_COMPLETE, 1'b0, 32'h8012_0100)); // payload read refused
        send_item(tick_item(TS_COMPLETE, 1'b1, $urandom));
        send_item(tick_item(TS_COMPLETE, 1'b1, 32'h80AB_0000)); // empty payload read
        send_item(tick_item(TS_UNDEFINED, 1'b1, $urandom));     // transport fails
        send_item(queue_item(8'h00, 16'd5));
        send_item(queue_item(8'hFF, 16'd0));
        send_item(queue_item(8'hFF, RST_MAX_WRITE_LEN + 16'd1));
        send_item(queue_item(8'hFF, RST_MAX_WRITE_LEN));
        send_item(queue_item(8'h01, 16'd1));                    // other tag pending
        send_item(queue_item(8'hFF, 16'd1));                    // replace length
        send_item(tick_item(TS_COMPLETE, 1'b1, $urandom));
        send_item(tick_item(TS_COMPLETE, 1'b1, 32'h0000_0040)); // write the packet
        send_item(queue_item(8'hFF, 16'd2));                    // write in flight
        send_item(tick_item(TS_COMPLETE, 1'b1, $urandom));
        send_item(command_item(CMD_SPARE));
        send_item(command_item(CMD_RESET));
        wait_idle();

        // Random phases, each under its own register settings
        for (int p = 0; p < 5; p++) begin
            case (p)
                0: c = '{16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF};
                1: c = '{16'd1, 16'd1, 8'h00, 8'h00, 8'h00};
                2: begin
                    c = '{16'($urandom_range(1, 600)), 16'($urandom_range(1, 600)),
                          8'($urandom), 8'($urandom), 8'($urandom)};
                    c.retry_code = c.retry_code & c.status_field_mask;
                end
                3: c = '{16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                         8'($urandom), 8'($urandom), 8'($urandom)};
                default: c = '{RST_RD_BUF_LIMIT, RST_MAX_WRITE_LEN, RST_STATUS_MASK,
                               RST_RETRY_CODE, RST_READY_MASK};
            endcase
            load_settings(c);
            if (p == 1) begin
                // every record is a retry here: refuse the status reads long enough
                // for the retry counter to saturate
                send_item(command_item(CMD_RESET));
                for (int n = 0; n < RETRY_ROUNDS; n++) begin
                    if (n % 25 == 0)
                        tx_gaps = ($urandom_range(0, 3) != 0);
                    send_item(tick_item(2'($urandom), 1'b1, $urandom));
                    send_item(tick_item(TS_COMPLETE, 1'b0, $urandom));
                end
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % 25 == 0)
                    tx_gaps = ($urandom_range(0, 3) != 0);
                send_item(random_item());
            end
            wait_idle();
        end

        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
